FILE: rtl/tdc_pkg.sv
// tdc_pkg: shared types, constants and the digit segment table for the
// thermometer display controller. No dependencies.
package tdc_pkg;

	localparam int unsigned ADC_W  = 8;
	localparam int unsigned TEMP_W = 8;
	localparam int unsigned SEG_W  = 7;
	localparam int unsigned SEL_W  = 4;
	localparam int unsigned LAMP_W = 3;
	localparam int unsigned DIG_W  = 4;
	localparam int unsigned POS_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MID_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT    = 2'd2;

	localparam logic [ADC_W-1:0] MID_THRESHOLD_RST  = 8'd50;
	localparam logic [ADC_W-1:0] HIGH_THRESHOLD_RST = 8'd75;
	localparam logic [ADC_W-1:0] UPPER_LIMIT_RST    = 8'd250;

	// scan positions
	localparam logic [POS_W-1:0] POS_TENS   = 2'd0;
	localparam logic [POS_W-1:0] POS_UNITS  = 2'd1;
	localparam logic [POS_W-1:0] POS_DEGREE = 2'd2;
	localparam logic [POS_W-1:0] POS_LETTER = 2'd3;

	localparam logic [SEG_W-1:0] SEG_DEGREE   = 7'h63;
	localparam logic [SEG_W-1:0] SEG_LETTER_C = 7'h39;
	localparam logic [SEG_W-1:0] SEG_LETTER_F = 7'h71;
	localparam logic [SEL_W-1:0] SELECT_FIRST = 4'b1000;
	localparam logic [TEMP_W-1:0] F_OFFSET    = 8'd32;

	localparam logic [LAMP_W-1:0] LAMP_OFF  = 3'b000;
	localparam logic [LAMP_W-1:0] LAMP_LOW  = 3'b001;
	localparam logic [LAMP_W-1:0] LAMP_MID  = 3'b010;
	localparam logic [LAMP_W-1:0] LAMP_HIGH = 3'b100;

	localparam logic [TEMP_W-1:0] TEMP_MAX = 8'd215;

	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic [DIG_W-1:0]  tens;
		logic [DIG_W-1:0]  units;
		logic [LAMP_W-1:0] lamp;
	} conv_t;

	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic [SEL_W-1:0] sel;
	} scan_t;

	function automatic logic [SEG_W-1:0] digit_seg(input logic [DIG_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = 7'h3F;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/tdc_convert.sv
// tdc_convert: sample to whole-degree temperature, BCD split and lamp choice.
// Combinational. Depends on tdc_pkg.
module tdc_convert import tdc_pkg::*; (
	input  logic [ADC_W-1:0] adc_sample,
	input  logic             f_mode,
	input  logic [ADC_W-1:0] mid_threshold,
	input  logic [ADC_W-1:0] high_threshold,
	input  logic [ADC_W-1:0] upper_limit,
	output conv_t            conv
);

	logic [8:0]        x_c;
	logic [16:0]       prod_c;
	logic [12:0]       x_f;
	logic [25:0]       prod_f;
	logic [TEMP_W-1:0] t_c;
	logic [TEMP_W-1:0] t_f;
	logic [TEMP_W-1:0] temp;
	logic [15:0]       prod_d;
	logic [4:0]        q10;
	logic [TEMP_W-1:0] q10_x10;

	// 2s/5 via *205>>10, exact for 2s < 1024
	assign x_c    = {adc_sample, 1'b0};
	assign prod_c = 17'(x_c) * 17'd205;
	assign t_c    = {1'b0, prod_c[16:10]};

	// 18s/25 via *5243>>17, exact for 18s < 43690
	assign x_f    = 13'({adc_sample, 4'b0}) + 13'({adc_sample, 1'b0});
	assign prod_f = 26'(x_f) * 26'd5243;
	assign t_f    = prod_f[24:17] + F_OFFSET;

	assign temp = f_mode ? t_f : t_c;

	// t/10 via *205>>11
	assign prod_d  = 16'(temp) * 16'd205;
	assign q10     = prod_d[15:11];
	assign q10_x10 = 8'({q10, 3'b0}) + 8'({q10, 1'b0});

	always_comb begin
		conv.temp  = temp;
		conv.units = DIG_W'(temp - q10_x10);
		if (q10 >= 5'd20) begin
			conv.tens = DIG_W'(q10 - 5'd20);
		end else if (q10 >= 5'd10) begin
			conv.tens = DIG_W'(q10 - 5'd10);
		end else begin
			conv.tens = DIG_W'(q10);
		end
		if (adc_sample >= upper_limit) begin
			conv.lamp = LAMP_OFF;
		end else if (adc_sample >= high_threshold) begin
			conv.lamp = LAMP_HIGH;
		end else if (adc_sample >= mid_threshold) begin
			conv.lamp = LAMP_MID;
		end else begin
			conv.lamp = LAMP_LOW;
		end
	end

endmodule

FILE: rtl/tdc_scan.sv
// tdc_scan: segment pattern and one-hot digit select for one scan position.
// Combinational. Depends on tdc_pkg.
module tdc_scan import tdc_pkg::*; (
	input  logic [POS_W-1:0] pos,
	input  logic [DIG_W-1:0] tens,
	input  logic [DIG_W-1:0] units,
	input  logic             f_mode,
	output scan_t            scan
);

	always_comb begin
		scan.sel = SELECT_FIRST >> pos;
		unique case (pos)
			POS_TENS:   scan.seg = digit_seg(tens);
			POS_UNITS:  scan.seg = digit_seg(units);
			POS_DEGREE: scan.seg = SEG_DEGREE;
			POS_LETTER: scan.seg = f_mode ? SEG_LETTER_F : SEG_LETTER_C;
			default:    scan.seg = SEG_DEGREE;
		endcase
	end

endmodule

FILE: rtl/thermometer_display_controller_unit.sv
// thermometer_display_controller_unit: top level, input and result registers,
// display state and configuration registers. Depends on tdc_pkg, tdc_convert, tdc_scan.

// Takes one transaction per clock: either an ADC sample (func = 0), which may flip the
// C/F mode, converts to whole degrees and picks a lamp, or a scan tick (func = 1), which
// returns the segment pattern and select for the next of tens, units, degree sign and
// unit letter. Every transaction gives exactly one result: the input register feeds
// the conversion and scan logic, whose output is captured in the result register when
// that register is empty or out_ready is high. Throughput is one transaction per cycle
// while out_ready stays high. The user must write the threshold registers through
// cfg_we/cfg_index/cfg_data only while idle; the block itself does not enforce it.
module thermometer_display_controller_unit import tdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADC_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [ADC_W-1:0]     adc_sample,
	input  logic                 unit_toggle,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 display_valid,
	output logic [SEG_W-1:0]     segments,
	output logic [SEL_W-1:0]     digit_select,
	output logic [LAMP_W-1:0]    lamps,
	output logic [TEMP_W-1:0]    temperature,
	output logic                 unit_is_f
);

	logic [ADC_W-1:0]  mid_threshold_q;
	logic [ADC_W-1:0]  high_threshold_q;
	logic [ADC_W-1:0]  upper_limit_q;

	logic              valid_s1;
	logic              func_s1;
	logic [ADC_W-1:0]  adc_s1;
	logic              toggle_s1;

	logic [POS_W-1:0]  pos_q;
	logic [DIG_W-1:0]  tens_q;
	logic [DIG_W-1:0]  units_q;
	logic              mode_q;
	logic [LAMP_W-1:0] lamp_q;
	logic [TEMP_W-1:0] temp_q;

	logic              valid_s2;
	logic              disp_s2;
	logic [SEG_W-1:0]  seg_s2;
	logic [SEL_W-1:0]  sel_s2;
	logic [LAMP_W-1:0] lamp_s2;
	logic [TEMP_W-1:0] temp_s2;
	logic              mode_s2;

	logic              adv;
	logic              fire;
	logic              new_mode;
	conv_t             conv;
	scan_t             scan;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;
	assign new_mode = mode_q ^ toggle_s1;

	tdc_convert u_convert (
		.adc_sample     (adc_s1),
		.f_mode         (new_mode),
		.mid_threshold  (mid_threshold_q),
		.high_threshold (high_threshold_q),
		.upper_limit    (upper_limit_q),
		.conv           (conv)
	);

	tdc_scan u_scan (
		.pos    (pos_q),
		.tens   (tens_q),
		.units  (units_q),
		.f_mode (mode_q),
		.scan   (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_threshold_q  <= MID_THRESHOLD_RST;
			high_threshold_q <= HIGH_THRESHOLD_RST;
			upper_limit_q    <= UPPER_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MID_THRESHOLD:  mid_threshold_q  <= cfg_data;
				REG_HIGH_THRESHOLD: high_threshold_q <= cfg_data;
				REG_UPPER_LIMIT:    upper_limit_q    <= cfg_data;
				default:            ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1   <= func;
			adc_s1    <= adc_sample;
			toggle_s1 <= unit_toggle;
		end
	end

	// display state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_TENS;
			tens_q  <= '0;
			units_q <= '0;
			mode_q  <= 1'b0;
			lamp_q  <= LAMP_OFF;
			temp_q  <= '0;
		end else if (fire) begin
			if (func_s1) begin
				pos_q <= pos_q + POS_W'(1);
			end else begin
				mode_q  <= new_mode;
				tens_q  <= conv.tens;
				units_q <= conv.units;
				lamp_q  <= conv.lamp;
				temp_q  <= conv.temp;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			disp_s2 <= func_s1;
			if (func_s1) begin
				seg_s2  <= scan.seg;
				sel_s2  <= scan.sel;
				lamp_s2 <= lamp_q;
				temp_s2 <= temp_q;
				mode_s2 <= mode_q;
			end else begin
				seg_s2  <= '0;
				sel_s2  <= '0;
				lamp_s2 <= conv.lamp;
				temp_s2 <= conv.temp;
				mode_s2 <= new_mode;
			end
		end
	end

	assign out_valid     = valid_s2;
	assign display_valid = disp_s2;
	assign segments      = seg_s2;
	assign digit_select  = sel_s2;
	assign lamps         = lamp_s2;
	assign temperature   = temp_s2;
	assign unit_is_f     = mode_s2;

`ifndef SYNTH
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");

	a_digits_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		(tens_q <= 4'd9) && (units_q <= 4'd9))
		else $error("stored digit out of range");

	a_select_matches: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ($onehot0(sel_s2) && (disp_s2 == (sel_s2 != '0))))
		else $error("digit select inconsistent with display_valid");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (temp_s2 <= TEMP_MAX))
		else $error("temperature out of range");
`endif

endmodule

FILE: sim/tb_thermometer_display_controller_unit.sv
`timescale 1ns / 100ps
// tb_thermometer_display_controller_unit: self-checking testbench for the thermometer
// display controller: directed and random sample/tick traffic checked against a predictor.
// Depends on tdc_pkg and thermometer_display_controller_unit.
module tb_thermometer_display_controller_unit;
	import tdc_pkg::*;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;
	localparam int   STALL_LIMIT = 3000;

	typedef struct packed {
		logic              disp_valid;
		logic [SEG_W-1:0]  seg;
		logic [SEL_W-1:0]  sel;
		logic [LAMP_W-1:0] lamp;
		logic [TEMP_W-1:0] temp;
		logic              in_f;
	} display_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADC_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 func;
	logic [ADC_W-1:0]     adc_sample;
	logic                 unit_toggle;
	logic                 out_valid;
	logic                 out_ready;
	logic                 display_valid;
	logic [SEG_W-1:0]     segments;
	logic [SEL_W-1:0]     digit_select;
	logic [LAMP_W-1:0]    lamps;
	logic [TEMP_W-1:0]    temperature;
	logic                 unit_is_f;

	thermometer_display_controller_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .adc_sample(adc_sample), .unit_toggle(unit_toggle),
		.out_valid(out_valid), .out_ready(out_ready),
		.display_valid(display_valid), .segments(segments), .digit_select(digit_select),
		.lamps(lamps), .temperature(temperature), .unit_is_f(unit_is_f)
	);

	// predictor state
	logic [SEG_W-1:0]  digit_pattern [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
		7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
	logic [ADC_W-1:0]  mid_thr;
	logic [ADC_W-1:0]  high_thr;
	logic [ADC_W-1:0]  upper_lim;
	logic [POS_W-1:0]  scan_pos;
	logic [DIG_W-1:0]  tens_dig;
	logic [DIG_W-1:0]  units_dig;
	logic              fahrenheit;
	logic [LAMP_W-1:0] lamp_now;
	logic [TEMP_W-1:0] last_deg;

	display_result_t pending_displays [$];
	int fail_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic display_result_t predict_display(input logic f,
			input logic [ADC_W-1:0] s, input logic t);
		display_result_t r;
		int unsigned sv;
		int unsigned deg;
		r = '0;
		sv = s;
		if (f == FUNC_SAMPLE) begin
			if (t) fahrenheit = ~fahrenheit;
			if (fahrenheit) deg = (18 * sv) / 25 + F_OFFSET;
			else deg = (2 * sv) / 5;
			last_deg  = deg[TEMP_W-1:0];
			tens_dig  = DIG_W'((deg / 10) % 10);
			units_dig = DIG_W'(deg % 10);
			if (s >= upper_lim) lamp_now = LAMP_OFF;
			else if (s >= high_thr) lamp_now = LAMP_HIGH;
			else if (s >= mid_thr) lamp_now = LAMP_MID;
			else lamp_now = LAMP_LOW;
		end else begin
			r.disp_valid = 1'b1;
			r.sel = SELECT_FIRST >> scan_pos;
			case (scan_pos)
				POS_TENS:   r.seg = digit_pattern[tens_dig];
				POS_UNITS:  r.seg = digit_pattern[units_dig];
				POS_DEGREE: r.seg = SEG_DEGREE;
				default:    r.seg = fahrenheit ? SEG_LETTER_F : SEG_LETTER_C;
			endcase
			scan_pos = scan_pos + 1'b1;
		end
		r.lamp = lamp_now;
		r.temp = last_deg;
		r.in_f = fahrenheit;
		return r;
	endfunction

	// result side: ready pattern and long hold-offs
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input logic [TEMP_W-1:0] got);
		if (got !== want[TEMP_W-1:0]) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		display_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_displays.size() == 0) begin
					$error("unexpected result transaction");
					fail_count++;
				end else begin
					want = pending_displays.pop_front();
					check_field("display_valid", want.disp_valid, display_valid);
					check_field("segments", want.seg, segments);
					check_field("digit_select", want.sel, digit_select);
					check_field("lamps", want.lamp, lamps);
					check_field("temperature", want.temp, temperature);
					check_field("unit_is_f", want.in_f, unit_is_f);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_item(input logic f, input logic [ADC_W-1:0] s, input logic t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		adc_sample  <= s;
		unit_toggle <= t;
		do @(posedge clk); while (!in_ready);
		pending_displays.push_back(predict_display(f, s, t));
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_displays.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADC_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MID_THRESHOLD:  mid_thr = val;
			REG_HIGH_THRESHOLD: high_thr = val;
			default:            upper_lim = val;
		endcase
		@(posedge clk);
	endtask

	task automatic set_thresholds(input logic [ADC_W-1:0] m, input logic [ADC_W-1:0] h,
			input logic [ADC_W-1:0] u);
		quiesce();
		write_reg(REG_MID_THRESHOLD, m);
		write_reg(REG_HIGH_THRESHOLD, h);
		write_reg(REG_UPPER_LIMIT, u);
	endtask

	function automatic logic [ADC_W-1:0] pick_sample();
		if ($urandom_range(99) < 30) begin
			case ($urandom_range(7))
				0: return '0;
				1: return '1;
				2: return mid_thr;
				3: return mid_thr - 1'b1;
				4: return high_thr;
				5: return high_thr - 1'b1;
				6: return upper_lim;
				default: return upper_lim - 1'b1;
			endcase
		end
		return ADC_W'($urandom);
	endfunction

	task automatic test_reset_scan();
		repeat (4) send_item(FUNC_TICK, '0, 1'b0);
	endtask

	task automatic test_conversion_extremes();
		send_item(FUNC_SAMPLE, 8'd0, 1'b0);
		send_item(FUNC_SAMPLE, 8'd255, 1'b0);
		send_item(FUNC_TICK, '0, 1'b0);
		send_item(FUNC_TICK, '0, 1'b0);
		send_item(FUNC_SAMPLE, 8'd255, 1'b1);
		// toggle and sample are ignored on ticks
		send_item(FUNC_TICK, 8'd255, 1'b1);
		send_item(FUNC_TICK, '0, 1'b0);
		send_item(FUNC_SAMPLE, 8'd0, 1'b0);
		send_item(FUNC_SAMPLE, 8'd0, 1'b1);
	endtask

	task automatic test_lamp_thresholds();
		// misordered: high below mid
		set_thresholds(8'd100, 8'd60, 8'd150);
		send_item(FUNC_SAMPLE, 8'd59, 1'b0);
		send_item(FUNC_SAMPLE, 8'd60, 1'b0);
		send_item(FUNC_SAMPLE, 8'd100, 1'b0);
		send_item(FUNC_SAMPLE, 8'd149, 1'b0);
		send_item(FUNC_SAMPLE, 8'd150, 1'b0);
	endtask

	task automatic test_mode_flip_letter();
		send_item(FUNC_SAMPLE, 8'd128, 1'b1);
		repeat (4) send_item(FUNC_TICK, ADC_W'($urandom), 1'($urandom));
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 300;
		repeat (40) send_item(1'($urandom), pick_sample(), 1'($urandom));
	endtask

	task automatic test_random_traffic(input int send_pct, input int stall_pct,
			input int n_items);
		int sent = 0;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		while (sent < n_items) begin
			if ($urandom_range(99) < 60) begin
				send_item(FUNC_SAMPLE, pick_sample(), $urandom_range(99) < 30);
				repeat (4) send_item(FUNC_TICK, ADC_W'($urandom), 1'($urandom));
				sent += 5;
			end else begin
				send_item(1'($urandom), ADC_W'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		func        <= FUNC_SAMPLE;
		adc_sample  <= '0;
		unit_toggle <= 1'b0;
		out_ready   <= 1'b0;
		fail_count     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		quiet_cycles   = 0;
		mid_thr    = MID_THRESHOLD_RST;
		high_thr   = HIGH_THRESHOLD_RST;
		upper_lim  = UPPER_LIMIT_RST;
		scan_pos   = POS_TENS;
		tens_dig   = '0;
		units_dig  = '0;
		fahrenheit = 1'b0;
		lamp_now   = LAMP_OFF;
		last_deg   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_scan();
		test_conversion_extremes();
		test_lamp_thresholds();
		test_mode_flip_letter();

		set_thresholds(ADC_W'($urandom), ADC_W'($urandom), ADC_W'($urandom));
		test_random_traffic(0, 0, 240);
		set_thresholds('1, '1, '1);
		test_random_traffic(73, 0, 240);
		set_thresholds('0, '0, '0);
		test_backpressure();
		set_thresholds(8'($urandom_range(0, 90)), 8'($urandom_range(91, 180)),
			8'($urandom_range(181, 255)));
		test_random_traffic(0, 73, 240);
		set_thresholds(8'($urandom_range(150, 255)), 8'($urandom_range(0, 100)),
			ADC_W'($urandom));
		test_random_traffic(6, 6, 240);

		quiesce();
		repeat (8) @(posedge clk);
		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
